// ===== design/owtr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package owtr_pkg;

    // sequencer phase codes
    localparam logic [4:0] PH_IDLE      = 5'd0;
    localparam logic [4:0] PH_R1_LOW    = 5'd1;
    localparam logic [4:0] PH_R1_WAIT   = 5'd2;
    localparam logic [4:0] PH_R1_TAIL   = 5'd3;
    localparam logic [4:0] PH_R1_NODEV  = 5'd4;
    localparam logic [4:0] PH_W_SKIP1   = 5'd5;
    localparam logic [4:0] PH_W_CONV    = 5'd6;
    localparam logic [4:0] PH_CONV_WAIT = 5'd7;
    localparam logic [4:0] PH_R2_LOW    = 5'd8;
    localparam logic [4:0] PH_R2_WAIT   = 5'd9;
    localparam logic [4:0] PH_R2_TAIL   = 5'd10;
    localparam logic [4:0] PH_W_SKIP2   = 5'd11;
    localparam logic [4:0] PH_W_READ    = 5'd12;
    localparam logic [4:0] PH_RD_LSB    = 5'd13;
    localparam logic [4:0] PH_RD_MSB    = 5'd14;

    // request codes on the mode field
    localparam logic [1:0] MODE_TICK      = 2'd0;
    localparam logic [1:0] MODE_FULL      = 2'd1;
    localparam logic [1:0] MODE_READ_ONLY = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_RESET_LOW     = 2'd0;
    localparam logic [1:0] CFG_PRESENCE_WAIT = 2'd1;
    localparam logic [1:0] CFG_PRESENCE_TAIL = 2'd2;
    localparam logic [1:0] CFG_CONVERT_WAIT  = 2'd3;

    // bus commands
    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_PAD = 8'hBE;

    // slot timing in ticks
    localparam logic [19:0] WR_SLOT_TICKS  = 20'd61;
    localparam logic [19:0] WR_ZERO_LOW    = 20'd60;
    localparam logic [19:0] WR_ONE_LOW     = 20'd1;
    localparam logic [19:0] RD_SLOT_TICKS  = 20'd60;
    localparam logic [19:0] RD_LOW_TICKS   = 20'd2;
    localparam logic [19:0] RD_SAMPLE_TICK = 20'd10;

    // register reset values
    localparam logic [9:0]  RESET_LOW_DEFAULT     = 10'd480;
    localparam logic [7:0]  PRESENCE_WAIT_DEFAULT = 8'd80;
    localparam logic [9:0]  PRESENCE_TAIL_DEFAULT = 10'd400;
    localparam logic [19:0] CONVERT_WAIT_DEFAULT  = 20'd750000;

    typedef struct packed {
        logic [9:0]  reset_low_ticks;
        logic [7:0]  presence_wait_ticks;
        logic [9:0]  presence_tail_ticks;
        logic [19:0] convert_wait_ticks;
    } owtr_cfg_t;

    typedef struct packed {
        logic [4:0]  phase;
        logic [19:0] tick_count;
        logic [2:0]  bit_index;
        logic [7:0]  shift_byte;
        logic [7:0]  low_byte;
        logic        read_only_mode;
    } owtr_state_t;

    typedef struct packed {
        logic               drive_low;
        logic               busy_res;
        logic               done_res;
        logic               no_device;
        logic signed [15:0] temperature;
    } owtr_result_t;

endpackage

`default_nettype wire

// ===== design/onewire_temperature_reader.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Single-wire bus master that reads a temperature sensor, one 1 us tick per
// input transaction. Each input transaction carries mode (0 tick, 1 start a
// full measurement, 2 start a read-only measurement) and the sampled bus
// level; each one produces exactly one output transaction with the bus drive,
// busy, a done pulse, the no-device flag and the raw temperature.
// Configuration registers (reset low, presence wait, presence tail, convert
// wait) are written through cfg_write/cfg_index/cfg_data by the user only
// while idle; the block does not enforce this. A result shows in the cycle
// after its input. Throughput: one tick per clock cycle when not stalled;
// the sequencer step is a single pass of logic between state and output registers.
// The output register frees in_ready whenever it is empty or being drained,
// so a stalled receiver holds the result and stops input only while it stalls.
// Reset: the sequencer returns to idle, the output is empty and the
// registers take their defaults (480, 80, 400, 750000 ticks).
module onewire_temperature_reader (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         mode,
    input  wire logic               line_level,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    drive_low,
    output logic                    busy_res,
    output logic                    done_res,
    output logic                    no_device,
    output logic signed [15:0]      temperature,
    input  wire logic               cfg_write,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [19:0]        cfg_data
);

    owtr_pkg::owtr_cfg_t    cfg_reg;
    owtr_pkg::owtr_state_t  state_reg;
    owtr_pkg::owtr_state_t  state_next;
    owtr_pkg::owtr_result_t step_res;
    owtr_pkg::owtr_result_t out_res;
    logic                   accept;

    assign accept = in_valid && in_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_ticks     <= owtr_pkg::RESET_LOW_DEFAULT;
            cfg_reg.presence_wait_ticks <= owtr_pkg::PRESENCE_WAIT_DEFAULT;
            cfg_reg.presence_tail_ticks <= owtr_pkg::PRESENCE_TAIL_DEFAULT;
            cfg_reg.convert_wait_ticks  <= owtr_pkg::CONVERT_WAIT_DEFAULT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                owtr_pkg::CFG_RESET_LOW:
                    cfg_reg.reset_low_ticks <= cfg_data[9:0];
                owtr_pkg::CFG_PRESENCE_WAIT:
                    cfg_reg.presence_wait_ticks <= cfg_data[7:0];
                owtr_pkg::CFG_PRESENCE_TAIL:
                    cfg_reg.presence_tail_ticks <= cfg_data[9:0];
                default:
                    cfg_reg.convert_wait_ticks <= cfg_data;
            endcase
        end
    end

    // sequencer state, advanced once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    owtr_step u_step (
        .cfg        (cfg_reg),
        .cur        (state_reg),
        .mode       (mode),
        .line_level (line_level),
        .nxt        (state_next),
        .res        (step_res)
    );

    owtr_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .res_in    (step_res),
        .out_ready (out_ready),
        .space     (in_ready),
        .out_valid (out_valid),
        .res_out   (out_res)
    );

    assign drive_low   = out_res.drive_low;
    assign busy_res    = out_res.busy_res;
    assign done_res    = out_res.done_res;
    assign no_device   = out_res.no_device;
    assign temperature = out_res.temperature;

endmodule

`default_nettype wire

// ===== design/owtr_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module owtr_step (
    input  wire owtr_pkg::owtr_cfg_t   cfg,
    input  wire owtr_pkg::owtr_state_t cur,
    input  wire logic [1:0]            mode,
    input  wire logic                  line_level,
    output owtr_pkg::owtr_state_t      nxt,
    output owtr_pkg::owtr_result_t     res
);

    logic        start;
    logic [4:0]  ph;
    logic [19:0] tc;
    logic [19:0] tc_inc;
    logic [19:0] tc_seg;
    logic [19:0] seg_len;
    logic        seg_end;
    logic [2:0]  bi;
    logic        ro;
    logic [7:0]  cmd;
    logic        cmd_bit;
    logic [7:0]  sb;

    // start request in idle takes effect on this tick
    always_comb
    begin
        start = (cur.phase == owtr_pkg::PH_IDLE)
             && (mode == owtr_pkg::MODE_FULL || mode == owtr_pkg::MODE_READ_ONLY);
        ph    = start ? owtr_pkg::PH_R1_LOW : cur.phase;
        tc    = start ? 20'd0 : cur.tick_count;
        bi    = start ? 3'd0 : cur.bit_index;
        ro    = start ? (mode == owtr_pkg::MODE_READ_ONLY) : cur.read_only_mode;
    end

    // segment length of the current phase
    always_comb
    begin
        case (ph) inside
            owtr_pkg::PH_R1_LOW, owtr_pkg::PH_R2_LOW:
                seg_len = {10'd0, cfg.reset_low_ticks};
            owtr_pkg::PH_R1_WAIT, owtr_pkg::PH_R2_WAIT:
                seg_len = {12'd0, cfg.presence_wait_ticks};
            owtr_pkg::PH_R1_TAIL, owtr_pkg::PH_R1_NODEV, owtr_pkg::PH_R2_TAIL:
                seg_len = {10'd0, cfg.presence_tail_ticks};
            owtr_pkg::PH_W_SKIP1, owtr_pkg::PH_W_CONV,
            owtr_pkg::PH_W_SKIP2, owtr_pkg::PH_W_READ:
                seg_len = owtr_pkg::WR_SLOT_TICKS;
            owtr_pkg::PH_CONV_WAIT:
                seg_len = cfg.convert_wait_ticks;
            owtr_pkg::PH_RD_LSB, owtr_pkg::PH_RD_MSB:
                seg_len = owtr_pkg::RD_SLOT_TICKS;
            default:
                seg_len = 20'd0;
        endcase
    end

    // segment counter advance
    assign tc_inc  = tc + 20'd1;
    assign seg_end = (tc_inc >= seg_len);
    assign tc_seg  = seg_end ? 20'd0 : tc_inc;

    // command byte and its current bit
    always_comb
    begin
        case (ph)
            owtr_pkg::PH_W_CONV: cmd = owtr_pkg::CMD_CONVERT;
            owtr_pkg::PH_W_READ: cmd = owtr_pkg::CMD_READ_PAD;
            default:             cmd = owtr_pkg::CMD_SKIP_ROM;
        endcase
        cmd_bit = cmd[bi];
    end

    // read shift byte, cleared at the first slot of a byte
    always_comb
    begin
        sb = (bi == 3'd0 && tc == 20'd0) ? 8'd0 : cur.shift_byte;
        if (tc == owtr_pkg::RD_SAMPLE_TICK && line_level)
        begin
            sb[bi] = 1'b1;
        end
    end

    // phase sequencer and per-tick result
    always_comb
    begin
        nxt.phase          = ph;
        nxt.tick_count     = tc_seg;
        nxt.bit_index      = bi;
        nxt.shift_byte     = cur.shift_byte;
        nxt.low_byte       = cur.low_byte;
        nxt.read_only_mode = ro;
        res.drive_low      = 1'b0;
        res.busy_res       = 1'b1;
        res.done_res       = 1'b0;
        res.no_device      = 1'b0;
        res.temperature    = 16'sd0;

        case (ph) inside
            owtr_pkg::PH_R1_LOW, owtr_pkg::PH_R2_LOW:
            begin
                res.drive_low = 1'b1;
                if (seg_end)
                begin
                    nxt.phase = ph + 5'd1;
                end
            end
            owtr_pkg::PH_R1_WAIT, owtr_pkg::PH_R2_WAIT:
            begin
                if (seg_end)
                begin
                    nxt.phase = ph + 5'd1;
                end
            end
            owtr_pkg::PH_R1_TAIL, owtr_pkg::PH_R1_NODEV:
            begin
                // high bus on the first tail tick means nobody answered
                if (ph == owtr_pkg::PH_R1_TAIL && tc == 20'd0 && line_level)
                begin
                    nxt.phase = owtr_pkg::PH_R1_NODEV;
                end
                if (seg_end)
                begin
                    if (nxt.phase == owtr_pkg::PH_R1_NODEV)
                    begin
                        res.done_res  = 1'b1;
                        res.no_device = 1'b1;
                        nxt.phase     = owtr_pkg::PH_IDLE;
                    end
                    else
                    begin
                        nxt.phase     = owtr_pkg::PH_W_SKIP1;
                        nxt.bit_index = 3'd0;
                    end
                end
            end
            owtr_pkg::PH_R2_TAIL:
            begin
                if (seg_end)
                begin
                    nxt.phase     = owtr_pkg::PH_W_SKIP2;
                    nxt.bit_index = 3'd0;
                end
            end
            owtr_pkg::PH_W_SKIP1, owtr_pkg::PH_W_CONV,
            owtr_pkg::PH_W_SKIP2, owtr_pkg::PH_W_READ:
            begin
                res.drive_low = (tc < (cmd_bit ? owtr_pkg::WR_ONE_LOW
                                               : owtr_pkg::WR_ZERO_LOW));
                if (seg_end)
                begin
                    if (bi == 3'd7)
                    begin
                        nxt.bit_index = 3'd0;
                        case (ph)
                            owtr_pkg::PH_W_SKIP1:
                                nxt.phase = ro ? owtr_pkg::PH_W_READ : owtr_pkg::PH_W_CONV;
                            owtr_pkg::PH_W_CONV:
                                nxt.phase = (cfg.convert_wait_ticks == 20'd0)
                                          ? owtr_pkg::PH_R2_LOW : owtr_pkg::PH_CONV_WAIT;
                            owtr_pkg::PH_W_SKIP2:
                                nxt.phase = owtr_pkg::PH_W_READ;
                            default:
                                nxt.phase = owtr_pkg::PH_RD_LSB;
                        endcase
                    end
                    else
                    begin
                        nxt.bit_index = bi + 3'd1;
                    end
                end
            end
            owtr_pkg::PH_CONV_WAIT:
            begin
                if (seg_end)
                begin
                    nxt.phase = owtr_pkg::PH_R2_LOW;
                end
            end
            owtr_pkg::PH_RD_LSB, owtr_pkg::PH_RD_MSB:
            begin
                nxt.shift_byte = sb;
                res.drive_low  = (tc < owtr_pkg::RD_LOW_TICKS);
                if (seg_end)
                begin
                    if (bi == 3'd7)
                    begin
                        nxt.bit_index = 3'd0;
                        if (ph == owtr_pkg::PH_RD_LSB)
                        begin
                            nxt.low_byte = sb;
                            nxt.phase    = owtr_pkg::PH_RD_MSB;
                        end
                        else
                        begin
                            res.temperature = {sb, cur.low_byte};
                            res.done_res    = 1'b1;
                            nxt.phase       = owtr_pkg::PH_IDLE;
                        end
                    end
                    else
                    begin
                        nxt.bit_index = bi + 3'd1;
                    end
                end
            end
            default:
            begin
                // idle: counter holds, nothing runs
                nxt.phase      = owtr_pkg::PH_IDLE;
                nxt.tick_count = tc;
                res.busy_res   = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/owtr_obuf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module owtr_obuf (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire owtr_pkg::owtr_result_t res_in,
    input  wire logic                   out_ready,
    output logic                        space,
    output logic                        out_valid,
    output owtr_pkg::owtr_result_t      res_out
);

    logic                   valid_reg;
    logic                   valid_next;
    owtr_pkg::owtr_result_t result_reg;

    // room for a new result when empty or being drained this cycle
    assign space      = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = result_reg;

endmodule

`default_nettype wire

// ===== design/owtr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module owtr_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic               drive_low,
    input wire logic               busy_res,
    input wire logic               done_res,
    input wire logic               no_device,
    input wire logic signed [15:0] temperature
);

    // an empty output register never blocks input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // done and no-device only come from a running sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (done_res || no_device) |-> busy_res && done_res)
        else $error("done or no_device outside a sequence");

    // a temperature only shows with a successful done
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (temperature != 16'sd0) |-> done_res && !no_device)
        else $error("temperature outside a successful done");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(temperature)
            && $stable(done_res) && $stable(drive_low))
        else $error("stalled result changed");

endmodule

bind onewire_temperature_reader owtr_checker u_owtr_checker (.*);

`default_nettype wire

// ===== dv/tb_onewire_temperature_reader.sv =====
`timescale 1ns / 1ps

module tb_onewire_temperature_reader;

    // mode code with no meaning of its own, taken as a plain tick
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    // cycles without any transaction before the run is abandoned
    localparam int QUIET_LIMIT = 500;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] mode = owtr_pkg::MODE_TICK;
    logic line_level = 1'b1;
    logic out_valid;
    logic out_ready = 1'b0;
    logic drive_low;
    logic busy_res;
    logic done_res;
    logic no_device;
    logic signed [15:0] temperature;
    logic cfg_write = 1'b0;
    logic [1:0] cfg_index = owtr_pkg::CFG_RESET_LOW;
    logic [19:0] cfg_data = '0;

    // local copy of the sequencer state
    logic [4:0] bus_phase = owtr_pkg::PH_IDLE;
    logic [19:0] seg_count = '0;
    logic [2:0] bit_pos = '0;
    logic [7:0] rx_byte = '0;
    logic [7:0] lsb_byte = '0;
    logic skip_convert = 1'b0;

    // local copy of the timing registers
    logic [9:0] low_len = owtr_pkg::RESET_LOW_DEFAULT;
    logic [7:0] wait_len = owtr_pkg::PRESENCE_WAIT_DEFAULT;
    logic [9:0] tail_len = owtr_pkg::PRESENCE_TAIL_DEFAULT;
    logic [19:0] conv_len = owtr_pkg::CONVERT_WAIT_DEFAULT;

    owtr_pkg::owtr_result_t bus_results_due[$];
    owtr_pkg::owtr_result_t due_res;
    int mismatches = 0;
    int quiet_cycles = 0;
    int stall_left = 0;
    bit calm = 1'b0;

    onewire_temperature_reader i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .line_level  (line_level),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .drive_low   (drive_low),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .no_device   (no_device),
        .temperature (temperature),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #10 clk = ~clk;

    // count one tick of the current segment, true when it has run out
    function automatic bit segment_ends(input logic [19:0] len);
        seg_count = seg_count + 20'd1;
        if (seg_count >= len)
        begin
            seg_count = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // advance the bus master by one tick and return its outputs for that tick
    function automatic owtr_pkg::owtr_result_t step_bus_master(input logic [1:0] req,
                                                               input logic level);
        owtr_pkg::owtr_result_t res;
        logic [7:0] cmd;
        logic cmd_bit;
        res = '0;
        res.busy_res = 1'b1;
        // start request from idle acts in the same tick
        if (bus_phase == owtr_pkg::PH_IDLE
            && (req == owtr_pkg::MODE_FULL || req == owtr_pkg::MODE_READ_ONLY))
        begin
            bus_phase = owtr_pkg::PH_R1_LOW;
            seg_count = '0;
            bit_pos = '0;
            skip_convert = (req == owtr_pkg::MODE_READ_ONLY);
        end
        case (bus_phase)
            owtr_pkg::PH_R1_LOW, owtr_pkg::PH_R2_LOW:
            begin
                res.drive_low = 1'b1;
                if (segment_ends({10'd0, low_len}))
                    bus_phase = bus_phase + 5'd1;
            end
            owtr_pkg::PH_R1_WAIT, owtr_pkg::PH_R2_WAIT:
            begin
                if (segment_ends({12'd0, wait_len}))
                    bus_phase = bus_phase + 5'd1;
            end
            owtr_pkg::PH_R1_TAIL:
            begin
                // presence is sampled on the first tail tick
                if (seg_count == '0 && level)
                    bus_phase = owtr_pkg::PH_R1_NODEV;
                if (segment_ends({10'd0, tail_len}))
                begin
                    if (bus_phase == owtr_pkg::PH_R1_NODEV)
                    begin
                        res.done_res = 1'b1;
                        res.no_device = 1'b1;
                        bus_phase = owtr_pkg::PH_IDLE;
                    end
                    else
                    begin
                        bus_phase = owtr_pkg::PH_W_SKIP1;
                        bit_pos = '0;
                    end
                end
            end
            owtr_pkg::PH_R1_NODEV:
            begin
                if (segment_ends({10'd0, tail_len}))
                begin
                    res.done_res = 1'b1;
                    res.no_device = 1'b1;
                    bus_phase = owtr_pkg::PH_IDLE;
                end
            end
            owtr_pkg::PH_R2_TAIL:
            begin
                if (segment_ends({10'd0, tail_len}))
                begin
                    bus_phase = owtr_pkg::PH_W_SKIP2;
                    bit_pos = '0;
                end
            end
            owtr_pkg::PH_W_SKIP1, owtr_pkg::PH_W_CONV,
            owtr_pkg::PH_W_SKIP2, owtr_pkg::PH_W_READ:
            begin
                // command bits go out lsb first, one write slot each
                if (bus_phase == owtr_pkg::PH_W_CONV)
                    cmd = owtr_pkg::CMD_CONVERT;
                else if (bus_phase == owtr_pkg::PH_W_READ)
                    cmd = owtr_pkg::CMD_READ_PAD;
                else
                    cmd = owtr_pkg::CMD_SKIP_ROM;
                cmd_bit = cmd[bit_pos];
                res.drive_low = (seg_count < (cmd_bit ? owtr_pkg::WR_ONE_LOW
                                                      : owtr_pkg::WR_ZERO_LOW));
                if (segment_ends(owtr_pkg::WR_SLOT_TICKS))
                begin
                    if (bit_pos == 3'd7)
                    begin
                        bit_pos = '0;
                        if (bus_phase == owtr_pkg::PH_W_SKIP1)
                            bus_phase = skip_convert ? owtr_pkg::PH_W_READ
                                                     : owtr_pkg::PH_W_CONV;
                        else if (bus_phase == owtr_pkg::PH_W_CONV)
                            bus_phase = (conv_len == '0) ? owtr_pkg::PH_R2_LOW
                                                         : owtr_pkg::PH_CONV_WAIT;
                        else if (bus_phase == owtr_pkg::PH_W_SKIP2)
                            bus_phase = owtr_pkg::PH_W_READ;
                        else
                            bus_phase = owtr_pkg::PH_RD_LSB;
                    end
                    else
                        bit_pos = bit_pos + 3'd1;
                end
            end
            owtr_pkg::PH_CONV_WAIT:
            begin
                if (segment_ends(conv_len))
                    bus_phase = owtr_pkg::PH_R2_LOW;
            end
            owtr_pkg::PH_RD_LSB, owtr_pkg::PH_RD_MSB:
            begin
                // read slots, sampled once per slot
                if (bit_pos == '0 && seg_count == '0)
                    rx_byte = '0;
                res.drive_low = (seg_count < owtr_pkg::RD_LOW_TICKS);
                if (seg_count == owtr_pkg::RD_SAMPLE_TICK && level)
                    rx_byte[bit_pos] = 1'b1;
                if (segment_ends(owtr_pkg::RD_SLOT_TICKS))
                begin
                    if (bit_pos == 3'd7)
                    begin
                        bit_pos = '0;
                        if (bus_phase == owtr_pkg::PH_RD_LSB)
                        begin
                            lsb_byte = rx_byte;
                            bus_phase = owtr_pkg::PH_RD_MSB;
                        end
                        else
                        begin
                            res.temperature = {rx_byte, lsb_byte};
                            res.done_res = 1'b1;
                            bus_phase = owtr_pkg::PH_IDLE;
                        end
                    end
                    else
                        bit_pos = bit_pos + 3'd1;
                end
            end
            default:
            begin
                bus_phase = owtr_pkg::PH_IDLE;
                res.busy_res = 1'b0;
            end
        endcase
        return res;
    endfunction

    // bus level a sensor would give on the coming tick
    function automatic logic pick_line(input bit present, input logic [15:0] word);
        if (bus_phase == owtr_pkg::PH_R1_TAIL && seg_count == '0)
            return !present;
        if (bus_phase == owtr_pkg::PH_RD_LSB && seg_count == owtr_pkg::RD_SAMPLE_TICK)
            return word[{1'b0, bit_pos}];
        if (bus_phase == owtr_pkg::PH_RD_MSB && seg_count == owtr_pkg::RD_SAMPLE_TICK)
            return word[{1'b1, bit_pos}];
        return 1'($urandom_range(0, 1));
    endfunction

    // mostly plain ticks, with stray requests mixed in
    function automatic logic [1:0] pick_mode(input int noise_pct);
        if ($urandom_range(0, 99) < noise_pct)
            return 2'($urandom_range(0, 3));
        return owtr_pkg::MODE_TICK;
    endfunction

    // send one tick transaction, then record what it should produce
    task automatic send_tick(input logic [1:0] req, input logic level,
                             output owtr_pkg::owtr_result_t res);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= req;
        line_level <= level;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        res = step_bus_master(req, level);
        bus_results_due.push_back(res);
    endtask

    // hold off input until every outstanding result has been seen
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (bus_results_due.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // program all four timing registers while the block is idle
    task automatic load_timing(input logic [9:0] rl, input logic [7:0] pw,
                               input logic [9:0] pt, input logic [19:0] cw);
        wait_for_results();
        cfg_write <= 1'b1;
        cfg_index <= owtr_pkg::CFG_RESET_LOW;
        cfg_data <= {10'd0, rl};
        @(posedge clk);
        cfg_index <= owtr_pkg::CFG_PRESENCE_WAIT;
        cfg_data <= {12'd0, pw};
        @(posedge clk);
        cfg_index <= owtr_pkg::CFG_PRESENCE_TAIL;
        cfg_data <= {10'd0, pt};
        @(posedge clk);
        cfg_index <= owtr_pkg::CFG_CONVERT_WAIT;
        cfg_data <= cw;
        @(posedge clk);
        cfg_write <= 1'b0;
        low_len = rl;
        wait_len = pw;
        tail_len = pt;
        conv_len = cw;
    endtask

    // one measurement from start request to done pulse
    task automatic run_measurement(input logic [1:0] start_req, input bit present,
                                   input logic [15:0] word, input int noise_pct);
        owtr_pkg::owtr_result_t res;
        send_tick(start_req, pick_line(present, word), res);
        while (!res.done_res)
            send_tick(pick_mode(noise_pct), pick_line(present, word), res);
    endtask

    // plain ticks and the unused mode while idle
    task automatic test_idle_ticks();
        owtr_pkg::owtr_result_t res;
        int i;
        for (i = 0; i < 8; i++)
            send_tick((i % 2 == 1) ? MODE_UNUSED : owtr_pkg::MODE_TICK,
                      1'((i / 2) % 2), res);
    endtask

    // register reset values with an absent sensor
    task automatic test_default_timing();
        run_measurement(owtr_pkg::MODE_FULL, 1'b0, 16'h0000, 10);
    endtask

    // no presence answer on both kinds of request, zero and longest segments
    task automatic test_no_device();
        load_timing(10'd3, 8'd2, 10'd5, 20'd7);
        run_measurement(owtr_pkg::MODE_FULL, 1'b0, 16'h1234, 20);
        run_measurement(owtr_pkg::MODE_READ_ONLY, 1'b0, 16'h1234, 20);
        load_timing(10'd0, 8'd0, 10'd0, 20'd0);
        run_measurement(owtr_pkg::MODE_FULL, 1'b0, 16'h1234, 20);
        load_timing(10'd1023, 8'd255, 10'd1023, 20'd1);
        run_measurement(owtr_pkg::MODE_READ_ONLY, 1'b0, 16'h1234, 10);
    endtask

    // random short timings with idle ticks and pauses in between
    task automatic test_random_no_device(input int count);
        owtr_pkg::owtr_result_t res;
        int n;
        int k;
        int idle_ticks;
        for (n = 0; n < count; n++)
        begin
            if (n % 2 == 0)
                load_timing(10'($urandom_range(0, 24)), 8'($urandom_range(0, 24)),
                            10'($urandom_range(0, 24)), 20'($urandom_range(0, 300)));
            else if ($urandom_range(0, 3) == 0)
                wait_for_results();
            idle_ticks = $urandom_range(0, 12);
            for (k = 0; k < idle_ticks; k++)
                send_tick($urandom_range(0, 1) ? MODE_UNUSED : owtr_pkg::MODE_TICK,
                          1'($urandom_range(0, 1)), res);
            run_measurement($urandom_range(0, 1) ? owtr_pkg::MODE_FULL
                                                 : owtr_pkg::MODE_READ_ONLY,
                            1'b0, 16'($urandom_range(0, 65535)), 20);
        end
    endtask

    // full measurements, with and without a conversion wait
    task automatic test_full_measurement();
        load_timing(10'd1, 8'd1, 10'd1, 20'd0);
        run_measurement(owtr_pkg::MODE_FULL, 1'b1, 16'hFE6F, 30);
        load_timing(10'd2, 8'd1, 10'd2, 20'd20);
        run_measurement(owtr_pkg::MODE_FULL, 1'b1, 16'h8001, 30);
    endtask

    // read-only measurement at full rate on both sides
    task automatic test_steady_stream();
        load_timing(10'd4, 8'd3, 10'd6, 20'd9);
        calm = 1'b1;
        run_measurement(owtr_pkg::MODE_READ_ONLY, 1'b1, 16'h7D91, 20);
    endtask

    // receiver stalls in random bursts
    always @(posedge clk)
    begin
        if (!calm && stall_left == 0 && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 9);
        if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // compare each output transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (bus_results_due.size() == 0)
            begin
                $error("output transaction with nothing pending");
                mismatches++;
            end
            else
            begin
                due_res = bus_results_due.pop_front();
                if (drive_low !== due_res.drive_low)
                begin
                    $error("drive_low: expected %0d, got %0d", due_res.drive_low, drive_low);
                    mismatches++;
                end
                if (busy_res !== due_res.busy_res)
                begin
                    $error("busy_res: expected %0d, got %0d", due_res.busy_res, busy_res);
                    mismatches++;
                end
                if (done_res !== due_res.done_res)
                begin
                    $error("done_res: expected %0d, got %0d", due_res.done_res, done_res);
                    mismatches++;
                end
                if (no_device !== due_res.no_device)
                begin
                    $error("no_device: expected %0d, got %0d", due_res.no_device, no_device);
                    mismatches++;
                end
                if (temperature !== due_res.temperature)
                begin
                    $error("temperature: expected %0d, got %0d",
                           due_res.temperature, temperature);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_ticks();
        test_default_timing();
        test_no_device();
        test_random_no_device(12);
        test_full_measurement();
        test_steady_stream();
        wait_for_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && bus_results_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
